@@ rtl/core/mwc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers of the minimum window cover search.
// Used by the channel interfaces and by every module of the block but mwc_ram.
package mwc_pkg;

  // Channel field widths.
  localparam int CH_W    = 8;
  localparam int START_W = 10;
  localparam int LEN_W   = 11;

  // Text buffer and letter table sizes.
  localparam int MAX_TEXT = 1024;
  localparam int ALPHA    = 58;
  localparam int ADDR_W   = $clog2(MAX_TEXT);
  localparam int POS_W    = $clog2(MAX_TEXT + 1);
  localparam int AW       = $clog2(ALPHA);
  localparam int REQ_W    = $clog2(ALPHA + 1);
  localparam int CODE_W   = 7;
  localparam int CNT_W    = 11;

  // Depth of the queue between front and back.
  localparam int QDEPTH = 4;

  localparam logic [CH_W-1:0]   FIRST_LETTER = 8'd65;
  localparam logic [CODE_W-1:0] FILLER_CODE  = 7'h7F;
  localparam logic [CNT_W-1:0]  PCNT_MAX     = '1;

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // One classified request as it travels from front to back.
  typedef struct packed {
    logic              op;
    logic [CODE_W-1:0] code;
    logic              last;
  } item_t;

  // Maps a byte to its letter index, or to the filler code.
  function automatic logic [CODE_W-1:0] letter_code(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] d;
    d = c - FIRST_LETTER;
    if (c >= FIRST_LETTER && d < CH_W'(ALPHA)) begin
      return CODE_W'(d);
    end
    return FILLER_CODE;
  endfunction

endpackage

@@ rtl/core/mwc_ifs.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and result sides.
// Depends on mwc_pkg for field widths.
interface mwc_in_if import mwc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            op;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source (output valid, op, ch, last, input ready);
  modport sink   (input valid, op, ch, last, output ready);
endinterface

interface mwc_out_if import mwc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [START_W-1:0] start_res;
  logic [LEN_W-1:0]   length;
  logic               overflow;

  modport source (output valid, found, start_res, length, overflow, input ready);
  modport sink   (input valid, found, start_res, length, overflow, output ready);
endinterface

@@ rtl/core/minimum_window_cover_search.sv @@
`timescale 1ns / 1ps
// Minimum window cover search. Pattern requests (op 0) are counted per
// letter 'A'..'z' and ignored once text has arrived; a text request is stored
// in the 1024-entry text buffer (or only sets the overflow flag once the buffer
// is full) and then drops letters from the left of the window one by one, each
// step reading or writing the letter table or the text buffer once; the final
// text request also delivers the result. A 4-entry queue sits between the
// request front end and the sequencer, and the result register lets a new
// request enter while a result waits. Depends on mwc_pkg, mwc_ifs, mwc_front,
// mwc_queue and mwc_back.
module minimum_window_cover_search import mwc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mwc_in_if.sink     in_chan,
  mwc_out_if.source  out_chan
);

  logic  fwd_valid, fwd_ready;
  item_t fwd_item;
  logic  q_valid, q_ready;
  item_t q_item;

  mwc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .fwd_valid (fwd_valid),
    .fwd_ready (fwd_ready),
    .fwd_item  (fwd_item)
  );

  mwc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fwd_valid),
    .push_ready (fwd_ready),
    .push_item  (fwd_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  mwc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .out_chan (out_chan)
  );

endmodule

@@ rtl/core/mwc_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/mwc_queue.sv @@
`timescale 1ns / 1ps
// Short request queue that decouples the front from the back.
// Depends on mwc_pkg for item_t and QDEPTH.
module mwc_queue import mwc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  item_t         slot_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != CW'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/core/mwc_front.sv @@
`timescale 1ns / 1ps
// Front end: takes requests from the input channel and classifies each
// character into a letter index or filler. Depends on mwc_pkg and mwc_in_if.
module mwc_front import mwc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mwc_in_if.sink      in_chan,
  output logic        fwd_valid,
  input  logic        fwd_ready,
  output item_t       fwd_item
);

  logic  stage_vld_r, stage_vld_nxt;
  item_t stage_item_r;
  logic  take;

  assign in_chan.ready = !stage_vld_r || fwd_ready;
  assign take          = in_chan.valid && in_chan.ready;
  assign fwd_valid     = stage_vld_r;
  assign fwd_item      = stage_item_r;

  always_comb begin
    stage_vld_nxt = stage_vld_r;
    if (take) begin
      stage_vld_nxt = 1'b1;
    end else if (fwd_ready) begin
      stage_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
    end
    if (take) begin
      stage_item_r.op   <= in_chan.op;
      stage_item_r.code <= letter_code(in_chan.ch);
      stage_item_r.last <= in_chan.last;
    end
  end

endmodule

@@ rtl/core/mwc_back.sv @@
`timescale 1ns / 1ps
// Back end: sequencer that keeps the letter tables and text buffer, slides
// the window and delivers the result. Depends on mwc_pkg, mwc_ram, mwc_out_if.
module mwc_back import mwc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  mwc_out_if.source   out_chan
);

  typedef enum logic [2:0] {
    S_IDLE, S_P_UPD, S_T_UPD, S_CHECK, S_L_TB, S_L_CNT, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [REQ_W-1:0]  matched_r, matched_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [ADDR_W-1:0] left_r, left_nxt;
  logic [ADDR_W-1:0] cur_pos_r, cur_pos_nxt;
  logic [ADDR_W-1:0] best_start_r, best_start_nxt;
  logic [POS_W-1:0]  best_len_r, best_len_nxt;
  logic              best_valid_r, best_valid_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              last_r, last_nxt;
  logic [ALPHA-1:0]  cnt_vld_r, cnt_vld_nxt;
  logic              cnt_hit_r;

  logic              out_valid_r, out_valid_nxt;
  logic              found_r, found_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              oflag_r, oflag_nxt;

  // Letter table memory: pattern count in the upper half, window count below.
  logic                 cnt_we;
  logic [AW-1:0]        cnt_waddr, cnt_raddr;
  logic [2*CNT_W-1:0]   cnt_wdata, cnt_rdata;
  logic [CNT_W-1:0]     ent_p, ent_w;

  logic                 tb_we;
  logic [ADDR_W-1:0]    tb_waddr, tb_raddr;
  logic [CODE_W-1:0]    tb_wdata, tb_rdata;

  logic                 rec_en;
  logic [ADDR_W-1:0]    rec_lo;
  logic [POS_W-1:0]     rec_len;
  logic [ADDR_W-1:0]    left_inc;
  logic [REQ_W-1:0]     drop_m;
  logic                 out_free;

  mwc_ram #(.WIDTH(2 * CNT_W), .DEPTH(ALPHA)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  mwc_ram #(.WIDTH(CODE_W), .DEPTH(MAX_TEXT)) u_text_ram (
    .clk   (clk),
    .we    (tb_we),
    .waddr (tb_waddr),
    .wdata (tb_wdata),
    .raddr (tb_raddr),
    .rdata (tb_rdata)
  );

  // An entry never written since the last clear reads as zero.
  assign ent_p = cnt_hit_r ? cnt_rdata[2*CNT_W-1:CNT_W] : '0;
  assign ent_w = cnt_hit_r ? cnt_rdata[CNT_W-1:0] : '0;

  assign left_inc = left_r + ADDR_W'(1);
  assign drop_m   = (ent_p != '0 && ent_w == ent_p && matched_r != '0) ?
                    matched_r - REQ_W'(1) : matched_r;
  assign q_ready  = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_chan.ready;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.found     = found_r;
  assign out_chan.start_res = start_r;
  assign out_chan.length    = len_r;
  assign out_chan.overflow  = oflag_r;

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    matched_nxt    = matched_r;
    pos_nxt        = pos_r;
    left_nxt       = left_r;
    cur_pos_nxt    = cur_pos_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    best_valid_nxt = best_valid_r;
    ovf_nxt        = ovf_r;
    code_nxt       = code_r;
    last_nxt       = last_r;
    cnt_vld_nxt    = cnt_vld_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    found_nxt      = found_r;
    start_nxt      = start_r;
    len_nxt        = len_r;
    oflag_nxt      = oflag_r;

    cnt_we    = 1'b0;
    cnt_waddr = code_r[AW-1:0];
    cnt_wdata = {ent_p, ent_w};
    cnt_raddr = q_item.code[AW-1:0];
    tb_we     = 1'b0;
    tb_waddr  = pos_r[ADDR_W-1:0];
    tb_wdata  = q_item.code;
    rec_en    = 1'b0;
    rec_lo    = left_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          code_nxt = q_item.code;
          last_nxt = q_item.last;
          if (q_item.op == OP_PATTERN) begin
            // Pattern letters only count before any text has arrived.
            if (pos_r == '0 && q_item.code < CODE_W'(ALPHA)) begin
              state_nxt = S_P_UPD;
            end
          end else if (pos_r >= POS_W'(MAX_TEXT)) begin
            ovf_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            tb_we       = 1'b1;
            cur_pos_nxt = pos_r[ADDR_W-1:0];
            pos_nxt     = pos_r + POS_W'(1);
            state_nxt   = (q_item.code < CODE_W'(ALPHA)) ? S_T_UPD : S_CHECK;
          end
        end
      end
      S_P_UPD: begin
        if (ent_p != PCNT_MAX) begin
          cnt_we    = 1'b1;
          cnt_wdata = {ent_p + CNT_W'(1), ent_w};
          if (ent_p == '0) begin
            req_nxt = req_r + REQ_W'(1);
          end
        end
        state_nxt = S_IDLE;
      end
      S_T_UPD: begin
        cnt_we    = 1'b1;
        cnt_wdata = {ent_p, ent_w + CNT_W'(1)};
        if (ent_p != '0 && ent_w + CNT_W'(1) == ent_p) begin
          matched_nxt = matched_r + REQ_W'(1);
        end
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (req_r != '0 && matched_r >= req_r) begin
          rec_en    = 1'b1;
          rec_lo    = left_r;
          state_nxt = (left_r < cur_pos_r) ? S_L_TB : S_FIN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_L_TB: begin
        code_nxt  = tb_rdata;
        cnt_raddr = tb_rdata[AW-1:0];
        if (tb_rdata < CODE_W'(ALPHA)) begin
          state_nxt = S_L_CNT;
        end else begin
          // Dropping filler leaves the cover intact.
          left_nxt  = left_inc;
          rec_en    = 1'b1;
          rec_lo    = left_inc;
          state_nxt = (left_inc < cur_pos_r) ? S_L_TB : S_FIN;
        end
      end
      S_L_CNT: begin
        cnt_we      = 1'b1;
        cnt_wdata   = {ent_p, (ent_w != '0) ? ent_w - CNT_W'(1) : ent_w};
        matched_nxt = drop_m;
        left_nxt    = left_inc;
        if (drop_m >= req_r) begin
          rec_en    = 1'b1;
          rec_lo    = left_inc;
          state_nxt = (left_inc < cur_pos_r) ? S_L_TB : S_FIN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          found_nxt      = best_valid_r;
          start_nxt      = best_valid_r ? START_W'(best_start_r) : '0;
          len_nxt        = best_valid_r ? LEN_W'(best_len_r) : '0;
          oflag_nxt      = ovf_r;
          req_nxt        = '0;
          matched_nxt    = '0;
          pos_nxt        = '0;
          left_nxt       = '0;
          best_start_nxt = '0;
          best_len_nxt   = '0;
          best_valid_nxt = 1'b0;
          ovf_nxt        = 1'b0;
          cnt_vld_nxt    = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Keep the earliest of equally short windows.
    rec_len = POS_W'(cur_pos_r) - POS_W'(rec_lo) + POS_W'(1);
    if (rec_en && (!best_valid_r || best_len_r > rec_len)) begin
      best_valid_nxt = 1'b1;
      best_start_nxt = rec_lo;
      best_len_nxt   = rec_len;
    end

    if (cnt_we) begin
      cnt_vld_nxt[cnt_waddr] = 1'b1;
    end
  end

  // The text read follows the left edge so the next drop finds its letter.
  assign tb_raddr = left_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      req_r        <= '0;
      matched_r    <= '0;
      pos_r        <= '0;
      left_r       <= '0;
      best_start_r <= '0;
      best_len_r   <= '0;
      best_valid_r <= 1'b0;
      ovf_r        <= 1'b0;
      cnt_vld_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      req_r        <= req_nxt;
      matched_r    <= matched_nxt;
      pos_r        <= pos_nxt;
      left_r       <= left_nxt;
      best_start_r <= best_start_nxt;
      best_len_r   <= best_len_nxt;
      best_valid_r <= best_valid_nxt;
      ovf_r        <= ovf_nxt;
      cnt_vld_r    <= cnt_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cur_pos_r <= cur_pos_nxt;
    code_r    <= code_nxt;
    last_r    <= last_nxt;
    found_r   <= found_nxt;
    start_r   <= start_nxt;
    len_r     <= len_nxt;
    oflag_r   <= oflag_nxt;
    cnt_hit_r <= (cnt_raddr < AW'(ALPHA)) ? cnt_vld_r[cnt_raddr] : 1'b0;
  end

  a_matched_le_req: assert property (@(posedge clk) disable iff (!rst_n)
    matched_r <= req_r)
    else $error("matched letter count exceeds required count");

  a_left_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    POS_W'(left_r) <= pos_r)
    else $error("window left edge passed the text position");

  a_best_sane: assert property (@(posedge clk) disable iff (!rst_n)
    best_valid_r |-> (best_len_r != '0 && best_len_r <= pos_r))
    else $error("recorded window length out of range");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish step");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for minimum_window_cover_search: sends pattern and text requests
// and checks every result against a shortest-cover predictor kept in the bench.
// Depends on mwc_pkg, mwc_ifs and the block's RTL.
module tb_top;
  import mwc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1100;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic               ovf;
  } cover_result_t;

  logic clk = 1'b0;
  logic rst_n;

  mwc_in_if  in_chan ();
  mwc_out_if out_chan ();

  minimum_window_cover_search dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [CNT_W-1:0]   want_cnt [ALPHA];
  logic [CNT_W-1:0]   seen_cnt [ALPHA];
  logic [CODE_W-1:0]  text_codes [MAX_TEXT];
  logic [REQ_W-1:0]   letters_needed;
  logic [REQ_W-1:0]   letters_met;
  logic [ADDR_W-1:0]  left_idx;
  logic [POS_W-1:0]   text_len;
  logic [START_W-1:0] best_start;
  logic [LEN_W-1:0]   best_len;
  logic               best_ok;
  logic               text_over;

  cover_result_t pending_covers [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int random_items = 0;
  logic steady = 1'b0;
  logic [CH_W-1:0] letter_pool [4];

  function automatic logic [CODE_W-1:0] code_of(input logic [CH_W-1:0] c);
    if (c >= FIRST_LETTER && c < FIRST_LETTER + CH_W'(ALPHA)) begin
      return CODE_W'(c - FIRST_LETTER);
    end
    return FILLER_CODE;
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < ALPHA; i++) begin
      want_cnt[i] = '0;
      seen_cnt[i] = '0;
    end
    letters_needed = '0;
    letters_met    = '0;
    left_idx       = '0;
    text_len       = '0;
    best_start     = '0;
    best_len       = '0;
    best_ok        = 1'b0;
    text_over      = 1'b0;
  endfunction

  // Only a strictly shorter window replaces the best, so ties keep the earliest.
  function automatic void note_window(input logic [ADDR_W-1:0] lo,
                                      input logic [ADDR_W-1:0] hi);
    logic [LEN_W-1:0] span;
    span = LEN_W'(hi) - LEN_W'(lo) + 1'b1;
    if (!best_ok || best_len > span) begin
      best_ok    = 1'b1;
      best_start = lo;
      best_len   = span;
    end
  endfunction

  function automatic void drop_oldest();
    logic [CODE_W-1:0] code;
    logic [AW-1:0]     idx;
    logic [CNT_W-1:0]  old;
    code = text_codes[left_idx];
    idx  = code[AW-1:0];
    if (code < CODE_W'(ALPHA)) begin
      old = seen_cnt[idx];
      if (old != 0) seen_cnt[idx] = old - 1'b1;
      if (want_cnt[idx] != 0 && old == want_cnt[idx] && letters_met != 0) begin
        letters_met = letters_met - 1'b1;
      end
    end
    left_idx = left_idx + 1'b1;
  endfunction

  function automatic void add_text(input logic [CODE_W-1:0] code);
    logic [ADDR_W-1:0] pos;
    logic [AW-1:0]     idx;
    pos = ADDR_W'(text_len);
    idx = code[AW-1:0];
    text_codes[pos] = code;
    text_len = text_len + 1'b1;
    if (code < CODE_W'(ALPHA)) begin
      seen_cnt[idx] = seen_cnt[idx] + 1'b1;
      if (want_cnt[idx] != 0 && seen_cnt[idx] == want_cnt[idx]) begin
        letters_met = letters_met + 1'b1;
      end
    end
    if (letters_needed == 0 || letters_met < letters_needed) return;
    note_window(left_idx, pos);
    while (left_idx < pos) begin
      drop_oldest();
      if (letters_met >= letters_needed) note_window(left_idx, pos);
      else break;
    end
  endfunction

  function automatic void predict_cover(input logic op, input logic [CH_W-1:0] ch,
                                        input logic is_last);
    logic [CODE_W-1:0] code;
    logic [AW-1:0]     idx;
    cover_result_t     res;
    code = code_of(ch);
    idx  = code[AW-1:0];
    if (op == OP_PATTERN) begin
      if (text_len == 0 && code < CODE_W'(ALPHA) && want_cnt[idx] < PCNT_MAX) begin
        want_cnt[idx] = want_cnt[idx] + 1'b1;
        if (want_cnt[idx] == 1) letters_needed = letters_needed + 1'b1;
      end
      return;
    end
    if (text_len >= POS_W'(MAX_TEXT)) text_over = 1'b1;
    else add_text(code);
    if (is_last) begin
      res.found = best_ok;
      res.start = best_ok ? best_start : '0;
      res.len   = best_ok ? best_len : '0;
      res.ovf   = text_over;
      pending_covers.push_back(res);
      clear_model();
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so the next request or an idle cycle follows without a glitch.
  task automatic send_req(input logic op, input logic [CH_W-1:0] ch, input logic is_last);
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.op    <= op;
    in_chan.ch    <= ch;
    in_chan.last  <= is_last;
    do @(posedge clk); while (!in_chan.ready);
    predict_cover(op, ch, is_last);
    @(negedge clk);
  endtask

  function automatic logic [CH_W-1:0] filler_byte();
    if ($urandom_range(0, 1)) return CH_W'($urandom_range(0, 64));
    return CH_W'($urandom_range(123, 255));
  endfunction

  function automatic logic [CH_W-1:0] any_letter();
    return FIRST_LETTER + CH_W'($urandom_range(0, ALPHA - 1));
  endfunction

  function automatic logic [CH_W-1:0] text_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return letter_pool[2'($urandom_range(0, 3))];
    if (roll < 85) return any_letter();
    return CH_W'($urandom_range(0, 255));
  endfunction

  // Range edges, filler on both sides of the letter range, a pattern request
  // after text has begun, a last flag on a pattern request, empty pattern and no cover.
  task automatic test_edge_cases();
    send_req(OP_PATTERN, "A", 1'b0);
    send_req(OP_PATTERN, "z", 1'b0);
    send_req(OP_PATTERN, 8'd64, 1'b0);
    send_req(OP_PATTERN, 8'd123, 1'b0);
    send_req(OP_PATTERN, "A", 1'b1);
    send_req(OP_TEXT, "z", 1'b0);
    send_req(OP_TEXT, 8'h00, 1'b0);
    send_req(OP_TEXT, "A", 1'b0);
    send_req(OP_TEXT, 8'hFF, 1'b0);
    send_req(OP_PATTERN, "B", 1'b0);
    send_req(OP_TEXT, "z", 1'b0);
    send_req(OP_TEXT, "A", 1'b1);
    send_req(OP_TEXT, "A", 1'b1);
    send_req(OP_PATTERN, "q", 1'b0);
    send_req(OP_PATTERN, "q", 1'b0);
    send_req(OP_TEXT, "q", 1'b0);
    send_req(OP_TEXT, "x", 1'b1);
  endtask

  // Drives the count of 'q' past 2047; a wrapped count would restart from zero and add 'q' to the required set again.
  task automatic test_count_saturation();
    repeat (2050) send_req(OP_PATTERN, "q", 1'b0);
    send_req(OP_PATTERN, "r", 1'b0);
    send_req(OP_TEXT, "r", 1'b0);
    send_req(OP_TEXT, "q", 1'b1);
  endtask

  // Full buffer: a cover spanning all 1024 positions, then one at the last position.
  task automatic test_text_overflow();
    send_req(OP_PATTERN, "A", 1'b0);
    send_req(OP_PATTERN, "z", 1'b0);
    send_req(OP_TEXT, "A", 1'b0);
    repeat (MAX_TEXT - 2) send_req(OP_TEXT, filler_byte(), 1'b0);
    send_req(OP_TEXT, "z", 1'b0);
    send_req(OP_TEXT, "A", 1'b0);
    send_req(OP_TEXT, "z", 1'b1);
    send_req(OP_PATTERN, "Q", 1'b0);
    repeat (MAX_TEXT - 1) send_req(OP_TEXT, filler_byte(), 1'b0);
    send_req(OP_TEXT, "Q", 1'b0);
    send_req(OP_TEXT, any_letter(), 1'b1);
  endtask

  task automatic test_random_sequences();
    int pat_len;
    int txt_len;
    while (random_items < RANDOM_ITEMS) begin
      steady = (random_items >= 400 && random_items < 650);
      for (int i = 0; i < 4; i++) letter_pool[i] = any_letter();
      pat_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      txt_len = $urandom_range(1, 30);
      for (int i = 0; i < pat_len; i++) begin
        if ($urandom_range(0, 9) < 8) begin
          send_req(OP_PATTERN, letter_pool[2'($urandom_range(0, 3))],
                   $urandom_range(0, 19) == 0);
        end else begin
          send_req(OP_PATTERN, CH_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        random_items++;
      end
      for (int i = 0; i < txt_len; i++) begin
        // A pattern request in the middle of the text must be ignored.
        if (i > 0 && $urandom_range(0, 19) == 0) begin
          send_req(OP_PATTERN, letter_pool[2'($urandom_range(0, 3))],
                   1'($urandom_range(0, 1)));
        end
        send_req(OP_TEXT, text_char(), i == txt_len - 1);
        random_items++;
      end
    end
    steady = 1'b0;
  endtask

  always @(negedge clk) begin
    out_chan.ready <= steady || ($urandom_range(0, 99) >= 32);
  end

  always @(posedge clk) begin : check_results
    cover_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_covers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: found=%0d start=%0d len=%0d ovf=%0d",
                   out_chan.found, out_chan.start_res, out_chan.length, out_chan.overflow);
        end
      end else begin
        want = pending_covers.pop_front();
        if (out_chan.found !== want.found || out_chan.start_res !== want.start ||
            out_chan.length !== want.len || out_chan.overflow !== want.ovf) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display({"result mismatch: expected found=%0d start=%0d len=%0d ovf=%0d,",
                      " got found=%0d start=%0d len=%0d ovf=%0d"},
                     want.found, want.start, want.len, want.ovf, out_chan.found,
                     out_chan.start_res, out_chan.length, out_chan.overflow);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.op     = OP_PATTERN;
    in_chan.ch     = '0;
    in_chan.last   = 1'b0;
    clear_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_edge_cases();
    test_count_saturation();
    test_text_overflow();
    test_random_sequences();

    in_chan.valid <= 1'b0;
    while (pending_covers.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ minimum_window_cover_search.f @@
rtl/core/mwc_pkg.sv
rtl/core/mwc_ifs.sv
rtl/core/mwc_ram.sv
rtl/core/mwc_queue.sv
rtl/core/mwc_front.sv
rtl/core/mwc_back.sv
rtl/core/minimum_window_cover_search.sv
verif/tb_top.sv
